>>> rtl/core/sha_pkg.sv
// shared types, round constants and initial hash values for the sha-256 hasher
package sha_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [7:0][31:0] t_chain;

    typedef enum logic [1:0] {
        SCH_IDLE,
        SCH_BYTE,
        SCH_PAD,
        SCH_SHIFT
    } t_sched_op;

    typedef enum logic [2:0] {
        CORE_IDLE,
        CORE_LOAD,
        CORE_ROUND,
        CORE_FOLD,
        CORE_INIT
    } t_core_op;

    typedef struct packed {
        t_sched_op   op;
        logic [5:0]  fill;
        logic [7:0]  data;
        logic        mark_placed;
        logic        with_len;
        logic [63:0] bit_len;
    } t_sched_ctrl;

    typedef struct packed {
        t_core_op   op;
        logic [5:0] round;
    } t_core_ctrl;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

endpackage

>>> rtl/core/sha_sched.sv
// block buffer and message schedule window: byte fill, padding and per-round shift
module sha_sched (
    input  logic                 i_clk,
    input  sha_pkg::t_sched_ctrl i_ctrl,
    output sha_pkg::t_word       o_w0
);

    sha_pkg::t_word r_win [16];
    sha_pkg::t_word n_win [16];
    sha_pkg::t_word w_new;
    sha_pkg::t_word s0;
    sha_pkg::t_word s1;

    assign s0 = {r_win[1][6:0], r_win[1][31:7]} ^ {r_win[1][17:0], r_win[1][31:18]}
              ^ (r_win[1] >> 3);
    assign s1 = {r_win[14][16:0], r_win[14][31:17]} ^ {r_win[14][18:0], r_win[14][31:19]}
              ^ (r_win[14] >> 10);
    assign w_new = s1 + r_win[9] + s0 + r_win[0];
    assign o_w0  = r_win[0];

    always_comb begin
        logic [5:0] v_pos;
        v_pos = 6'd0;
        for (int i = 0; i < 16; i++) n_win[i] = r_win[i];
        case (i_ctrl.op)
            sha_pkg::SCH_BYTE: begin
                // byte 0 of a word sits in the top lane
                for (int l = 0; l < 4; l++) begin
                    if (i_ctrl.fill[1:0] == 2'(l))
                        n_win[i_ctrl.fill[5:2]][31 - 8 * l -: 8] = i_ctrl.data;
                end
            end
            sha_pkg::SCH_PAD: begin
                for (int w = 0; w < 16; w++) begin
                    for (int l = 0; l < 4; l++) begin
                        v_pos = 6'(w * 4 + l);
                        if (i_ctrl.mark_placed)
                            n_win[w][31 - 8 * l -: 8] = 8'h00;
                        else if (v_pos == i_ctrl.fill)
                            n_win[w][31 - 8 * l -: 8] = sha_pkg::PAD_MARK;
                        else if (v_pos > i_ctrl.fill)
                            n_win[w][31 - 8 * l -: 8] = 8'h00;
                    end
                end
                if (i_ctrl.with_len) begin
                    n_win[14] = i_ctrl.bit_len[63:32];
                    n_win[15] = i_ctrl.bit_len[31:0];
                end
            end
            sha_pkg::SCH_SHIFT: begin
                for (int i = 0; i < 15; i++) n_win[i] = r_win[i + 1];
                n_win[15] = w_new;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) r_win[i] <= n_win[i];
    end

endmodule

>>> rtl/core/sha_core.sv
// compression round unit with working variables and chaining words
module sha_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_core_ctrl i_ctrl,
    input  sha_pkg::t_word      i_w,
    output sha_pkg::t_chain     o_chain
);

    sha_pkg::t_chain r_chain;
    sha_pkg::t_chain n_chain;
    sha_pkg::t_chain r_v;
    sha_pkg::t_chain n_v;

    sha_pkg::t_word big0, big1, choose, major, t1, t2;
    sha_pkg::t_word va, vb, vc, ve, vf, vg, vh;

    assign va = r_v[0];
    assign vb = r_v[1];
    assign vc = r_v[2];
    assign ve = r_v[4];
    assign vf = r_v[5];
    assign vg = r_v[6];
    assign vh = r_v[7];

    assign big1   = {ve[5:0], ve[31:6]} ^ {ve[10:0], ve[31:11]} ^ {ve[24:0], ve[31:25]};
    assign choose = (ve & vf) ^ (~ve & vg);
    assign t1     = vh + big1 + choose + sha_pkg::round_k(i_ctrl.round) + i_w;
    assign big0   = {va[1:0], va[31:2]} ^ {va[12:0], va[31:13]} ^ {va[21:0], va[31:22]};
    assign major  = (va & vb) ^ (va & vc) ^ (vb & vc);
    assign t2     = big0 + major;

    assign o_chain = r_chain;

    always_comb begin
        n_chain = r_chain;
        n_v     = r_v;
        case (i_ctrl.op)
            sha_pkg::CORE_LOAD:  n_v = r_chain;
            sha_pkg::CORE_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
            end
            sha_pkg::CORE_FOLD: begin
                for (int i = 0; i < 8; i++) n_chain[i] = r_chain[i] + r_v[i];
            end
            sha_pkg::CORE_INIT: begin
                for (int i = 0; i < 8; i++) n_chain[i] = sha_pkg::init_hash(3'(i));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= sha_pkg::init_hash(3'(i));
        end else begin
            r_chain <= n_chain;
        end
        r_v <= n_v;
    end

endmodule

>>> rtl/core/sha256_stream_hasher.sv
// top level: byte intake, padding sequencer and digest output
// Takes one message byte per transfer and computes SHA-256 over the stream. A byte
// that does not complete a 64-byte block is written into the block buffer. The transfer
// that completes a block holds the input while the single round unit runs the 64
// rounds at one per cycle and a fold step then adds the result into the chaining words.
// A transfer with end_of_message (with or without a byte) adds one padding step and
// one compression, or two of each when fewer than nine bytes of room remain in the
// block, after any compression that its own byte triggers. The digest then leaves as
// eight 32-bit words, index 0 first, one per output transfer, and the hasher restarts
// for the next message once the last word is taken. Input stall is high from the
// accepted transfer that starts work until the fold of its compression, or, for a
// transfer with end_of_message, until the last digest word is taken.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_FOLD = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_bytes, n_bytes;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;
    logic        r_pending, n_pending;
    logic        r_final, n_final;
    logic        r_mark, n_mark;

    sha_pkg::t_sched_ctrl sched_ctrl;
    sha_pkg::t_core_ctrl  core_ctrl;
    sha_pkg::t_word       w0;
    sha_pkg::t_chain      chain;

    logic in_xfer;
    logic out_xfer;
    logic fits_len;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;

    assign o_digest_word = chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    // length goes into this block if the end mark is already out or it leaves room
    assign fits_len = r_mark || (r_fill < sha_pkg::LEN_OFFSET);

    sha_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (sched_ctrl),
        .o_w0   (w0)
    );

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (core_ctrl),
        .i_w     (w0),
        .o_chain (chain)
    );

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_bytes   = r_bytes;
        n_round   = r_round;
        n_idx     = r_idx;
        n_pending = r_pending;
        n_final   = r_final;
        n_mark    = r_mark;

        sched_ctrl.op          = sha_pkg::SCH_IDLE;
        sched_ctrl.fill        = r_fill;
        sched_ctrl.data        = i_data_byte;
        sched_ctrl.mark_placed = r_mark;
        sched_ctrl.with_len    = fits_len;
        sched_ctrl.bit_len     = {r_bytes, 3'b000};
        core_ctrl.op           = sha_pkg::CORE_IDLE;
        core_ctrl.round        = r_round;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_byte_valid) begin
                        sched_ctrl.op = sha_pkg::SCH_BYTE;
                        n_fill  = r_fill + 6'd1;
                        n_bytes = r_bytes + 61'd1;
                        if (r_fill == 6'd63) begin
                            core_ctrl.op = sha_pkg::CORE_LOAD;
                            n_round   = 6'd0;
                            n_pending = i_end_of_message;
                            n_final   = 1'b0;
                            n_state   = ST_COMP;
                        end else if (i_end_of_message) begin
                            n_state = ST_PAD;
                        end
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sched_ctrl.op = sha_pkg::SCH_PAD;
                core_ctrl.op  = sha_pkg::CORE_LOAD;
                n_round   = 6'd0;
                n_final   = fits_len;
                n_pending = !fits_len;
                n_mark    = 1'b1;
                n_state   = ST_COMP;
            end
            ST_COMP: begin
                sched_ctrl.op = sha_pkg::SCH_SHIFT;
                core_ctrl.op  = sha_pkg::CORE_ROUND;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                core_ctrl.op = sha_pkg::CORE_FOLD;
                n_idx = 3'd0;
                if (r_final)        n_state = ST_EMIT;
                else if (r_pending) n_state = ST_PAD;
                else                n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (out_xfer) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        // restart for the next message
                        core_ctrl.op = sha_pkg::CORE_INIT;
                        n_fill    = 6'd0;
                        n_bytes   = 61'd0;
                        n_pending = 1'b0;
                        n_final   = 1'b0;
                        n_mark    = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= 6'd0;
            r_bytes   <= 61'd0;
            r_round   <= 6'd0;
            r_idx     <= 3'd0;
            r_pending <= 1'b0;
            r_final   <= 1'b0;
            r_mark    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_bytes   <= n_bytes;
            r_round   <= n_round;
            r_idx     <= n_idx;
            r_pending <= n_pending;
            r_final   <= n_final;
            r_mark    <= n_mark;
        end
    end

    a_no_intake_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while digest words pending");

    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !o_last_word) |=>
            (o_out_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word sequence broken");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_last_word) |=>
            (!o_out_valid && !o_in_stall && r_fill == 6'd0 && r_bytes == 61'd0))
        else $error("no clean restart after last digest word");

    a_rounds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP && r_round == 6'd63) |=> (r_state == ST_FOLD))
        else $error("compression did not end after 64 rounds");

endmodule
